[rtl/core/rmti_pkg.sv]
// Shared types, widths and helpers for the revolved mesh triangle indexer.
// Used by every module under rtl/core; depends on nothing.
package rmti_pkg;

    localparam int TRI_W    = 21;          // triangle number
    localparam int REG_W    = 11;          // rotate_count / curve_count
    localparam int CORNER_W = 20;          // vertex index
    localparam int D_W      = REG_W + 1;   // 2*R, the band length
    localparam int PROD_W   = 2 * REG_W;   // (C-2)*R
    localparam int TOT_W    = PROD_W + 1;  // (C-2)*2R
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    localparam int REG_MIN = 3;
    localparam int REG_MAX = (1 << REG_W) - 1;

    localparam int MAX_ROTATE_DEF = 1024;
    localparam int MAX_CURVE_DEF  = 1024;

    // Register index, taken from paddr[2]
    localparam logic IDX_ROTATE = 1'b0;
    localparam logic IDX_CURVE  = 1'b1;

    // Per-item control that travels with the data
    typedef struct packed {
        logic valid;
        logic oor;   // beyond the last triangle
        logic top;   // top fan
        logic mid;   // middle bands; neither top nor mid means bottom fan
    } ctl_t;

    // Payload carried alongside the divider
    typedef struct packed {
        logic [TRI_W-1:0] t;    // triangle number, for the top fan
        logic [REG_W-1:0] jb;   // ring position in the bottom fan
    } side_t;

    // Effective configuration, clamped and with its products worked out
    typedef struct packed {
        logic [REG_W-1:0] r;          // R
        logic [D_W-1:0]   d;          // 2R
        logic [TOT_W-1:0] total;      // (C-2)*2R
        logic [TOT_W-1:0] bot_start;  // first bottom fan triangle
        logic [TOT_W-1:0] last;       // bottom pole vertex
        logic [TOT_W-1:0] bot_first;  // first vertex of the last ring
    } cfg_t;

    function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v,
                                                   input logic [REG_W-1:0] hi);
        logic [REG_W-1:0] res;
        res = v;
        if (v < REG_W'(REG_MIN))
            res = REG_W'(REG_MIN);
        else if (v > hi)
            res = hi;
        return res;
    endfunction

endpackage

[rtl/core/rmti_cfg.sv]
// Configuration registers on the APB-style port, plus the clamped geometry
// values derived from them. Depends on rmti_pkg.
module rmti_cfg #(
    parameter int MAX_ROTATE = rmti_pkg::MAX_ROTATE_DEF,
    parameter int MAX_CURVE  = rmti_pkg::MAX_CURVE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rmti_pkg::ADDR_W-1:0]   paddr,
    input  logic [rmti_pkg::DATA_W-1:0]   pwdata,
    output logic [rmti_pkg::DATA_W-1:0]   prdata,
    output rmti_pkg::cfg_t                cfg
);

    localparam int CAP_R_I = (MAX_ROTATE < rmti_pkg::REG_MAX) ? MAX_ROTATE : rmti_pkg::REG_MAX;
    localparam int CAP_C_I = (MAX_CURVE < rmti_pkg::REG_MAX) ? MAX_CURVE : rmti_pkg::REG_MAX;
    localparam logic [rmti_pkg::REG_W-1:0] CAP_R = rmti_pkg::REG_W'(CAP_R_I);
    localparam logic [rmti_pkg::REG_W-1:0] CAP_C = rmti_pkg::REG_W'(CAP_C_I);
    localparam logic [rmti_pkg::REG_W-1:0] RST_VAL = rmti_pkg::REG_W'(rmti_pkg::REG_MIN);
    // Geometry for R = 3, C = 3
    localparam rmti_pkg::cfg_t CFG_RST = '{
        r:         rmti_pkg::REG_W'(3),
        d:         rmti_pkg::D_W'(6),
        total:     rmti_pkg::TOT_W'(6),
        bot_start: rmti_pkg::TOT_W'(3),
        last:      rmti_pkg::TOT_W'(4),
        bot_first: rmti_pkg::TOT_W'(1)
    };

    logic                        wr_en;
    logic [rmti_pkg::REG_W-1:0]  rotate_reg, rotate_next;
    logic [rmti_pkg::REG_W-1:0]  curve_reg, curve_next;
    logic [rmti_pkg::REG_W-1:0]  r_eff, c_eff, c_m2;
    logic [rmti_pkg::PROD_W-1:0] prod;
    rmti_pkg::cfg_t              cfg_reg, cfg_next;

    assign wr_en = psel & penable & pwrite;

    always_comb
    begin
        rotate_next = rotate_reg;
        curve_next  = curve_reg;
        if (wr_en && (paddr[2] == rmti_pkg::IDX_ROTATE))
            rotate_next = pwdata[rmti_pkg::REG_W-1:0];
        if (wr_en && (paddr[2] == rmti_pkg::IDX_CURVE))
            curve_next = pwdata[rmti_pkg::REG_W-1:0];
    end

    // Derive the geometry from the values about to be stored
    always_comb
    begin
        r_eff = rmti_pkg::clamp_reg(rotate_next, CAP_R);
        c_eff = rmti_pkg::clamp_reg(curve_next, CAP_C);
        c_m2  = c_eff - rmti_pkg::REG_W'(2);
        prod  = {{rmti_pkg::REG_W{1'b0}}, c_m2} * {{rmti_pkg::REG_W{1'b0}}, r_eff};
        cfg_next.r         = r_eff;
        cfg_next.d         = {r_eff, 1'b0};
        cfg_next.total     = {prod, 1'b0};
        cfg_next.bot_start = {prod, 1'b0} - rmti_pkg::TOT_W'(r_eff);
        cfg_next.last      = rmti_pkg::TOT_W'(prod) + rmti_pkg::TOT_W'(1);
        cfg_next.bot_first = rmti_pkg::TOT_W'(prod) + rmti_pkg::TOT_W'(1)
                           - rmti_pkg::TOT_W'(r_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotate_reg <= RST_VAL;
            curve_reg  <= RST_VAL;
            cfg_reg    <= CFG_RST;
        end
        else
        begin
            rotate_reg <= rotate_next;
            curve_reg  <= curve_next;
            cfg_reg    <= cfg_next;
        end
    end

    assign prdata = (paddr[2] == rmti_pkg::IDX_ROTATE)
                  ? {{(rmti_pkg::DATA_W-rmti_pkg::REG_W){1'b0}}, rotate_reg}
                  : {{(rmti_pkg::DATA_W-rmti_pkg::REG_W){1'b0}}, curve_reg};

    assign cfg = cfg_reg;

endmodule

[rtl/core/rmti_classify.sv]
// Entry stage: sort a triangle number into top fan, middle bands, bottom
// fan or out of range, and form the band offset. Depends on rmti_pkg.
module rmti_classify (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [rmti_pkg::TRI_W-1:0]  tri_number,
    input  rmti_pkg::cfg_t              cfg,
    output rmti_pkg::ctl_t              ctl,
    output rmti_pkg::side_t             side,
    output logic [rmti_pkg::TRI_W-1:0]  u
);

    logic [rmti_pkg::TOT_W-1:0] t_ext;
    rmti_pkg::ctl_t             ctl_reg, ctl_next;
    rmti_pkg::side_t            side_reg, side_next;
    logic [rmti_pkg::TRI_W-1:0] u_reg, u_next;

    // All compares run in parallel against precomputed bounds
    always_comb
    begin
        t_ext          = rmti_pkg::TOT_W'(tri_number);
        ctl_next.valid = in_valid;
        ctl_next.oor   = (t_ext >= cfg.total);
        ctl_next.top   = !ctl_next.oor && (t_ext < rmti_pkg::TOT_W'(cfg.r));
        ctl_next.mid   = !ctl_next.oor && !ctl_next.top && (t_ext < cfg.bot_start);
        side_next.t    = tri_number;
        side_next.jb   = rmti_pkg::REG_W'(t_ext - cfg.bot_start);
        u_next         = tri_number - rmti_pkg::TRI_W'(cfg.r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_next;
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        u_reg    <= u_next;
    end

    assign ctl  = ctl_reg;
    assign side = side_reg;
    assign u    = u_reg;

endmodule

[rtl/core/rmti_div_stage.sv]
// One restoring-division step: settle quotient bit SHIFT of offset / 2R.
// Depends on rmti_pkg.
module rmti_div_stage #(
    parameter int QW    = 10,
    parameter int SHIFT = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rmti_pkg::ctl_t              ctl_in,
    input  rmti_pkg::side_t             side_in,
    input  logic [rmti_pkg::TRI_W-1:0]  rem_in,
    input  logic [QW-1:0]               quo_in,
    input  logic [rmti_pkg::D_W-1:0]    d,
    output rmti_pkg::ctl_t              ctl_out,
    output rmti_pkg::side_t             side_out,
    output logic [rmti_pkg::TRI_W-1:0]  rem_out,
    output logic [QW-1:0]               quo_out
);

    localparam int CW = (rmti_pkg::TRI_W > rmti_pkg::D_W + SHIFT)
                      ? rmti_pkg::TRI_W : rmti_pkg::D_W + SHIFT;

    logic [CW-1:0]              rem_ext, d_sh;
    logic                       ge;
    logic [rmti_pkg::TRI_W-1:0] rem_next;
    logic [QW-1:0]              quo_next;
    rmti_pkg::ctl_t             ctl_reg;
    rmti_pkg::side_t            side_reg;
    logic [rmti_pkg::TRI_W-1:0] rem_reg;
    logic [QW-1:0]              quo_reg;

    always_comb
    begin
        rem_ext  = CW'(rem_in);
        d_sh     = CW'(d) << SHIFT;
        ge       = (rem_ext >= d_sh);
        rem_next = ge ? rmti_pkg::TRI_W'(rem_ext - d_sh) : rem_in;
        quo_next = quo_in;
        quo_next[SHIFT] = ge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_in;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign ctl_out  = ctl_reg;
    assign side_out = side_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;

endmodule

[rtl/core/rmti_corner.sv]
// Last two stages: ring base multiply, then corner assembly for each region
// into the result registers. Depends on rmti_pkg.
module rmti_corner #(
    parameter int QW = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rmti_pkg::ctl_t                 ctl_in,
    input  rmti_pkg::side_t                side_in,
    input  logic [rmti_pkg::TRI_W-1:0]     rem_in,
    input  logic [QW-1:0]                  quo_in,
    input  rmti_pkg::cfg_t                 cfg,
    output logic                           done,
    output logic [rmti_pkg::CORNER_W-1:0]  corner_a,
    output logic [rmti_pkg::CORNER_W-1:0]  corner_b,
    output logic [rmti_pkg::CORNER_W-1:0]  corner_c,
    output logic                           out_of_range
);

    localparam int BW = QW + 1 + rmti_pkg::REG_W;
    localparam int VW = ((BW > rmti_pkg::TOT_W) ? BW : rmti_pkg::TOT_W) + 1;

    // Multiply stage
    logic [rmti_pkg::REG_W-1:0] j_m, pj_m;
    logic [BW-1:0]              base_next;
    rmti_pkg::ctl_t             ctl_m_reg;
    rmti_pkg::side_t            side_m_reg;
    logic [BW-1:0]              base_reg;
    logic [rmti_pkg::D_W-1:0]   j1_reg, pj1_reg;
    logic                       odd_reg;

    // Assembly stage
    logic [VW-1:0] r_w, v_m, p_m, b_m, c_m, t_w, jb_w, v_b, p_b;
    logic [VW-1:0] ka, kb, kc;
    logic                          done_reg;
    logic                          oor_reg;
    logic [rmti_pkg::CORNER_W-1:0] a_reg, b_reg, c_reg;

    always_comb
    begin
        j_m       = rem_in[rmti_pkg::D_W-1:1];
        pj_m      = (j_m == '0) ? (cfg.r - rmti_pkg::REG_W'(1)) : (j_m - rmti_pkg::REG_W'(1));
        base_next = ({1'b0, quo_in} + (QW+1)'(1)) * BW'(cfg.r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_m_reg <= '0;
        else
            ctl_m_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        side_m_reg <= side_in;
        base_reg   <= base_next;
        j1_reg     <= rmti_pkg::D_W'(j_m) + rmti_pkg::D_W'(1);
        pj1_reg    <= rmti_pkg::D_W'(pj_m) + rmti_pkg::D_W'(1);
        odd_reg    <= rem_in[0];
    end

    always_comb
    begin
        r_w  = VW'(cfg.r);
        // middle bands: v on the current ring, b and c one ring up
        v_m  = VW'(base_reg) + VW'(j1_reg);
        p_m  = VW'(base_reg) + VW'(pj1_reg);
        b_m  = v_m - r_w;
        c_m  = p_m - r_w;
        // top fan
        t_w  = VW'(side_m_reg.t);
        // bottom fan
        jb_w = VW'(side_m_reg.jb);
        v_b  = VW'(cfg.bot_first) + jb_w;
        p_b  = (jb_w == '0) ? (VW'(cfg.last) - VW'(1)) : (v_b - VW'(1));

        ka = '0;
        kb = '0;
        kc = '0;
        if (ctl_m_reg.oor)
        begin
            ka = '0;
        end
        else if (ctl_m_reg.top)
        begin
            kb = (t_w == '0) ? r_w : t_w;
            kc = t_w + VW'(1);
        end
        else if (ctl_m_reg.mid)
        begin
            ka = v_m;
            kb = odd_reg ? b_m : c_m;
            kc = odd_reg ? c_m : p_m;
        end
        else
        begin
            ka = v_b;
            kb = p_b;
            kc = VW'(cfg.last);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl_m_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        oor_reg <= ctl_m_reg.oor;
        a_reg   <= ka[rmti_pkg::CORNER_W-1:0];
        b_reg   <= kb[rmti_pkg::CORNER_W-1:0];
        c_reg   <= kc[rmti_pkg::CORNER_W-1:0];
    end

    assign done         = done_reg;
    assign corner_a     = a_reg;
    assign corner_b     = b_reg;
    assign corner_c     = c_reg;
    assign out_of_range = oor_reg;

endmodule

[rtl/core/revolved_mesh_triangle_indexer_core.sv]
// Top level of the revolved mesh triangle indexer: config port, entry
// stage, division pipeline and corner stages. Depends on rmti_pkg.
//
//   Channel   Ports                                      Moves
//   --------  -----------------------------------------  ---------------------------
//   request   start, busy, tri_number                    triangle number in
//   result    done, corner_a, corner_b, corner_c,        three vertex indices and
//             out_of_range                               the range flag out
//   config    psel, penable, pwrite, paddr, pwdata,      rotate_count at 0x0,
//             prdata, pready                             curve_count at 0x4
//
// One transfer enters per cycle; busy is never raised. Each request passes through
// the entry, division, multiply and assembly stages and comes out as one done
// pulse. QW = clog2(min(MAX_CURVE, 2047)) is the number of quotient bits of the
// band division, one bit per stage. Results leave in request order and must be
// taken on the done cycle. Reset clears the valid bits of every stage and loads
// R = 3, C = 3; no clearing pass is needed.
module revolved_mesh_triangle_indexer_core #(
    parameter int MAX_ROTATE = rmti_pkg::MAX_ROTATE_DEF,
    parameter int MAX_CURVE  = rmti_pkg::MAX_CURVE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request
    input  logic                           start,
    output logic                           busy,
    input  logic [rmti_pkg::TRI_W-1:0]     tri_number,
    // result
    output logic                           done,
    output logic [rmti_pkg::CORNER_W-1:0]  corner_a,
    output logic [rmti_pkg::CORNER_W-1:0]  corner_b,
    output logic [rmti_pkg::CORNER_W-1:0]  corner_c,
    output logic                           out_of_range,
    // config
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rmti_pkg::ADDR_W-1:0]    paddr,
    input  logic [rmti_pkg::DATA_W-1:0]    pwdata,
    output logic [rmti_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    // Bands run from 0 to C-4, so the quotient needs clog2 of the capped C
    localparam int CAP_C = (MAX_CURVE < rmti_pkg::REG_MAX) ? MAX_CURVE : rmti_pkg::REG_MAX;
    localparam int QW    = $clog2(CAP_C);

    rmti_pkg::cfg_t cfg;
    logic           accept;

    // Division pipeline taps: index 0 is the entry stage output
    rmti_pkg::ctl_t             ctl_s  [QW+1];
    rmti_pkg::side_t            side_s [QW+1];
    logic [rmti_pkg::TRI_W-1:0] rem_s  [QW+1];
    logic [QW-1:0]              quo_s  [QW+1];

    // Every stage advances each cycle, so a request is always taken
    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign pready = 1'b1;

    rmti_cfg #(
        .MAX_ROTATE (MAX_ROTATE),
        .MAX_CURVE  (MAX_CURVE)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Classify and form the offset into the middle bands
    rmti_classify u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .tri_number (tri_number),
        .cfg        (cfg),
        .ctl        (ctl_s[0]),
        .side       (side_s[0]),
        .u          (rem_s[0])
    );

    assign quo_s[0] = '0;

    // Offset / 2R, most significant quotient bit first: band and position
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        rmti_div_stage #(
            .QW    (QW),
            .SHIFT (QW - 1 - k)
        ) u_div_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (ctl_s[k]),
            .side_in  (side_s[k]),
            .rem_in   (rem_s[k]),
            .quo_in   (quo_s[k]),
            .d        (cfg.d),
            .ctl_out  (ctl_s[k+1]),
            .side_out (side_s[k+1]),
            .rem_out  (rem_s[k+1]),
            .quo_out  (quo_s[k+1])
        );
    end

    // Ring base multiply, then the corners into the result registers
    rmti_corner #(
        .QW (QW)
    ) u_corner (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl_in       (ctl_s[QW]),
        .side_in      (side_s[QW]),
        .rem_in       (rem_s[QW]),
        .quo_in       (quo_s[QW]),
        .cfg          (cfg),
        .done         (done),
        .corner_a     (corner_a),
        .corner_b     (corner_b),
        .corner_c     (corner_c),
        .out_of_range (out_of_range)
    );

endmodule
